/* rtl/core/swm_pkg.sv */
// ----------------------------------------------------------------------------
// swm_pkg
// Shared widths and constants for the sliding window mean block.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int WINDOW_MAX = 64;
    localparam int SAMPLE_W   = 16;
    localparam int LEN_W      = $clog2(WINDOW_MAX) + 1;
    localparam int PTR_W      = $clog2(WINDOW_MAX);
    localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW_MAX);
    localparam int DIV_STEPS  = SUM_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);

endpackage

/* rtl/core/swm_div.sv */
// ----------------------------------------------------------------------------
// swm_div
// Restoring divider for the window sum: one quotient bit per cycle,
// truncates toward zero. Result is held until taken.
// ----------------------------------------------------------------------------
module swm_div
    import swm_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [SUM_W-1:0]    dividend,
    input  logic        [LEN_W-1:0]    divisor,
    input  logic                       take,
    output logic                       busy,
    output logic                       done,
    output logic signed [SAMPLE_W-1:0] quotient
);

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_RUN  = 3'b010,
        D_DONE = 3'b100
    } div_state_t;

    div_state_t           state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [SUM_W-1:0]     quo_reg;
    logic [LEN_W-1:0]     rem_reg;
    logic [LEN_W-1:0]     div_reg;
    logic                 neg_reg;

    logic [LEN_W:0]       rem_shift;
    logic                 fits;
    logic [LEN_W-1:0]     rem_step;
    logic [SUM_W-1:0]     mag;
    logic [SAMPLE_W-1:0]  q_low;

    assign mag       = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign fits      = rem_shift >= {1'b0, div_reg};
    // remainder stays below the divisor, so it fits back in LEN_W bits
    assign rem_step  = fits ? LEN_W'(rem_shift - {1'b0, div_reg}) : rem_shift[LEN_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            D_IDLE:
            begin
                if (start)
                    state_next = D_RUN;
            end
            D_RUN:
            begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    state_next = D_DONE;
            end
            D_DONE:
            begin
                if (take)
                    state_next = D_IDLE;
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == D_RUN)
                cnt_reg <= cnt_reg + CNT_W'(1);
            else
                cnt_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == D_IDLE && start)
        begin
            quo_reg <= mag;
            rem_reg <= '0;
            div_reg <= divisor;
            neg_reg <= dividend[SUM_W-1];
        end
        else if (state_reg == D_RUN)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
            rem_reg <= rem_step;
        end
    end

    // magnitude of the mean is at most 2^15, the low bits carry it exactly
    assign q_low    = quo_reg[SAMPLE_W-1:0];
    assign quotient = neg_reg ? SAMPLE_W'(-q_low) : q_low;
    assign busy     = state_reg != D_IDLE;
    assign done     = state_reg == D_DONE;

endmodule

/* rtl/core/sliding_window_mean_top.sv */
// ----------------------------------------------------------------------------
// sliding_window_mean_top
// Boxcar moving average over a stream of signed 16-bit samples.
// ----------------------------------------------------------------------------
// path: ring read, sum update, bit-serial divider, then the output register,
//   which takes a mean once free; a new sample waits until the last has passed
//   the sum update and until any mean it gave is in the output register
// reset: window length 2, sum, pointer and fill count cleared; the sample ring
//   is not cleared, only slots written in the current series are used in the sum
module sliding_window_mean_top
    import swm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [LEN_W-1:0]    cfg_wr_data,     // window_length
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [15:0]         s_axis_tdata,    // [15:0] sample
    input  logic                s_axis_tuser,    // [0] series_start
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [15:0]         m_axis_tdata     // [15:0] mean
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_UPD  = 3'b010,
        S_DIV  = 3'b100
    } state_t;

    state_t                     state_reg, state_next;
    logic [LEN_W-1:0]           len_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic [PTR_W-1:0]           ptr_reg;
    logic [LEN_W-1:0]           fill_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       sub_reg;
    logic                       emit_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_mean_reg;

    logic signed [SAMPLE_W-1:0] mem [WINDOW_MAX];
    logic signed [SAMPLE_W-1:0] rd_data_reg;

    logic [LEN_W-1:0]           m_eff;
    logic                       accept;
    logic [LEN_W-1:0]           fill_eff;
    logic [LEN_W-1:0]           fill_new;
    logic [PTR_W-1:0]           ptr_eff;
    logic [PTR_W-1:0]           slot;
    logic [LEN_W-1:0]           slot_inc;
    logic [PTR_W-1:0]           ptr_new;
    logic signed [SUM_W-1:0]    sum_next;
    logic                       div_start;
    logic                       div_busy;
    logic                       div_done;
    logic                       div_take;
    logic signed [SAMPLE_W-1:0] div_q;

    always_comb
    begin
        priority if (len_reg == '0)
            m_eff = LEN_W'(1);
        else if (len_reg > LEN_W'(WINDOW_MAX))
            m_eff = LEN_W'(WINDOW_MAX);
        else
            m_eff = len_reg;
    end

    assign s_axis_tready = state_reg == S_IDLE;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // series start clears the window before this sample goes in
    assign fill_eff = s_axis_tuser ? '0 : fill_reg;
    assign ptr_eff  = s_axis_tuser ? '0 : ptr_reg;
    assign slot     = ({1'b0, ptr_eff} >= m_eff) ? '0 : ptr_eff;
    assign slot_inc = {1'b0, slot} + LEN_W'(1);
    assign ptr_new  = (slot_inc >= m_eff) ? '0 : slot_inc[PTR_W-1:0];
    assign fill_new = (fill_eff < m_eff) ? fill_eff + LEN_W'(1) : fill_eff;

    assign sum_next = sum_reg
                    - (sub_reg ? SUM_W'(rd_data_reg) : SUM_W'(0))
                    + SUM_W'(sample_reg);

    assign div_start = (state_reg == S_UPD) && emit_reg;
    assign div_take  = div_done && (!out_valid_reg || m_axis_tready);

    // read of the old slot and write of the new sample share one edge
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= mem[slot];
            mem[slot]   <= s_axis_tdata;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_UPD;
            end
            S_UPD:
            begin
                if (emit_reg)
                    state_next = S_DIV;
                else
                    state_next = S_IDLE;
            end
            S_DIV:
            begin
                if (div_take)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= LEN_W'(2);
            sum_reg       <= '0;
            ptr_reg       <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                len_reg  <= cfg_wr_data;
                sum_reg  <= '0;
                ptr_reg  <= '0;
                fill_reg <= '0;
            end
            else if (accept)
            begin
                if (s_axis_tuser)
                    sum_reg <= '0;
                ptr_reg  <= ptr_new;
                fill_reg <= fill_new;
            end
            else if (state_reg == S_UPD)
            begin
                sum_reg <= sum_next;
            end

            if (div_take)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= s_axis_tdata;
            sub_reg    <= fill_eff >= m_eff;
            emit_reg   <= fill_new >= m_eff;
        end
        if (div_take)
            out_mean_reg <= div_q;
    end

    swm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (m_eff),
        .take     (div_take),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_mean_reg;

    a_upd_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_UPD |-> $past(accept))
        else $error("sum update without an accepted word");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= m_eff)
        else $error("fill count above window length");

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, ptr_reg} < m_eff)
        else $error("write pointer outside window");

    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_out_from_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(div_done))
        else $error("output word without a finished division");

endmodule
